### rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Types and constants shared by the pushbuffer command puller modules.
// ----------------------------------------------------------------------------
package pcp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned FADDR_W = 28;
	localparam int unsigned METH_W  = 14;
	localparam int unsigned SUBCH_W = 3;
	localparam int unsigned COUNT_W = 11;

	localparam logic [FADDR_W-1:0] RAM_LIMIT_RESET = 28'h400_0000;
	localparam logic [METH_W-1:0]  SOFT_METHOD     = 14'h0100;
	localparam logic [METH_W-1:0]  METHOD_STEP     = 14'd4;
	localparam logic [4:0]         FLIP_CODE       = 5'd1;
	localparam logic [WORD_W-1:0]  SURFACE_MASK    = 32'h0FFF_FFF0;

	// Low two bits of a header word.
	localparam logic [1:0] LOW_PLAIN = 2'd0;
	localparam logic [1:0] LOW_JUMP  = 2'd1;
	localparam logic [1:0] LOW_CALL  = 2'd2;

	// Top three bits of a header word.
	localparam logic [2:0] TOP_OLD_JUMP = 3'b001;
	localparam logic [2:0] TOP_NONINC   = 3'b010;

	// A return header carries this tag in its upper half.
	localparam logic [15:0] RETURN_TAG = 16'h0002;

	typedef enum logic [2:0] {
		KIND_METHOD  = 3'd0,
		KIND_HEADER  = 3'd1,
		KIND_JUMP    = 3'd2,
		KIND_CALL    = 3'd3,
		KIND_RETURN  = 3'd4,
		KIND_IGNORED = 3'd5,
		KIND_BAD     = 3'd6
	} kind_t;

	// One classified beat, as passed from the front end to the back end.
	typedef struct packed {
		kind_t               kind;
		logic [SUBCH_W-1:0]  subch;
		logic [METH_W-1:0]   meth;
		logic [WORD_W-1:0]   value;
		logic [FADDR_W-1:0]  next_fetch;
	} cmd_t;

endpackage

### rtl/pcp_ifs.sv
// ----------------------------------------------------------------------------
// pcp_ifs
// Valid/ready channels for fetched words and for decoded results.
// ----------------------------------------------------------------------------
interface pcp_fetch_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic [27:0] fetch_addr;

	modport source (output valid, output word, output fetch_addr, input ready);
	modport sink   (input valid, input word, input fetch_addr, output ready);
endinterface

interface pcp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [2:0]  subchannel;
	logic [13:0] method_addr;
	logic [31:0] param_value;
	logic [27:0] next_fetch;
	logic        soft_method;
	logic        flip_request;
	logic [27:0] flip_surface;

	modport source (output valid, output kind, output subchannel, output method_addr,
		output param_value, output next_fetch, output soft_method,
		output flip_request, output flip_surface, input ready);
	modport sink   (input valid, input kind, input subchannel, input method_addr,
		input param_value, input next_fetch, input soft_method,
		input flip_request, input flip_surface, output ready);
endinterface

### rtl/pushbuffer_command_puller_top.sv
// ----------------------------------------------------------------------------
// pushbuffer_command_puller_top
// Pushbuffer command decoder: one fetched word in, one decoded result out.
// ----------------------------------------------------------------------------
// Every fetched pushbuffer word, with the address it came from, gives exactly
// one result beat. The block takes one word per cycle while the queue has room;
// each beat passes through the queue and then the output register. The front
// end decodes a word combinationally against the pending parameter count, the
// current method and the saved return address, which it updates at once, so
// back-to-back words are decoded correctly. A two-entry queue decouples it from
// the back end, which flags software methods and flips and drives a registered
// result port. The result side may stall freely; the fetch side sees ready
// drop only once the queue and the output register are both full. Fetch
// addresses, and jump or call targets other than old-style jumps, at or above
// ram_limit give a bad-address result; after one the host must resync its fetch
// pointer. Write ram_limit only while no beats are in flight. ADDR_BITS sets the
// address wrap width.
// ----------------------------------------------------------------------------
module pushbuffer_command_puller_top
	import pcp_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FADDR_W-1:0] cfg_data,
	pcp_fetch_if.sink          fetch,
	pcp_result_if.source       result
);

	// Classified beat leaving the front end and entering the queue.
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// Head of the queue as seen by the back end.
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// Front end: decode and all sequencing state.
	pcp_front #(
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (fetch.valid),
		.in_ready (fetch.ready),
		.in_word  (fetch.word),
		.in_addr  (fetch.fetch_addr),
		.push     (push),
		.cmd      (push_cmd),
		.q_full   (q_full)
	);

	// The queue lets the front keep decoding while a result waits.
	pcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Back end: flag computation and the output register.
	pcp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

### rtl/pcp_front.sv
// ----------------------------------------------------------------------------
// pcp_front
// Classifies each fetched word and keeps the method and call state.
// ----------------------------------------------------------------------------
module pcp_front
	import pcp_pkg::*;
#(
	parameter int unsigned ADDR_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FADDR_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WORD_W-1:0]  in_word,
	input  logic [FADDR_W-1:0] in_addr,
	output logic               push,
	output cmd_t               cmd,
	input  logic               q_full
);

	localparam int unsigned AW = (ADDR_BITS < FADDR_W) ? ADDR_BITS : FADDR_W;
	localparam logic [FADDR_W-1:0] AMASK = FADDR_W'((33'd1 << AW) - 33'd1);

	logic [FADDR_W-1:0] ram_limit_q;
	logic [COUNT_W-1:0] params_left_q;
	logic [METH_W-1:0]  cur_method_q;
	logic [SUBCH_W-1:0] cur_subch_q;
	logic               same_mode_q;
	logic [FADDR_W-1:0] return_addr_q;

	logic [FADDR_W-1:0] addr;
	logic [FADDR_W-1:0] seq;
	logic [FADDR_W-1:0] target;
	logic [1:0]         low;
	logic [2:0]         top;
	logic               bad_fetch;
	logic               in_method;
	logic               target_oob;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign addr       = in_addr & AMASK;
	assign seq        = (addr + FADDR_W'(4)) & AMASK;
	assign target     = in_word[FADDR_W-1:0] & 28'hFFF_FFFC & AMASK;
	assign low        = in_word[1:0];
	assign top        = in_word[31:29];
	assign bad_fetch  = addr >= ram_limit_q;
	assign in_method  = params_left_q != '0;
	assign target_oob = (low == LOW_JUMP || low == LOW_CALL) && target >= ram_limit_q;

	always_comb begin
		cmd = '{kind: KIND_IGNORED, subch: '0, meth: '0, value: '0, next_fetch: seq};
		if (bad_fetch) begin
			cmd.kind       = KIND_BAD;
			cmd.next_fetch = '0;
		end else if (in_method) begin
			cmd.kind  = KIND_METHOD;
			cmd.subch = cur_subch_q;
			cmd.meth  = cur_method_q;
			cmd.value = in_word;
		end else if (target_oob) begin
			cmd.kind       = KIND_BAD;
			cmd.next_fetch = '0;
		end else if ((top == TOP_OLD_JUMP && low == LOW_PLAIN) || low == LOW_JUMP) begin
			cmd.kind       = KIND_JUMP;
			cmd.next_fetch = target;
		end else if (low == LOW_CALL) begin
			cmd.kind       = KIND_CALL;
			cmd.next_fetch = target;
		end else if (in_word[31:16] == RETURN_TAG && low == LOW_PLAIN) begin
			cmd.kind       = KIND_RETURN;
			cmd.next_fetch = return_addr_q;
		end else if (in_word[17:16] == 2'b00 && low == LOW_PLAIN) begin
			cmd.kind = KIND_HEADER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_limit_q   <= RAM_LIMIT_RESET;
			params_left_q <= '0;
			cur_method_q  <= '0;
			cur_subch_q   <= '0;
			same_mode_q   <= 1'b0;
			return_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				ram_limit_q <= cfg_data;
			end
			if (push) begin
				unique case (cmd.kind)
					KIND_BAD: begin
						if (bad_fetch) begin
							params_left_q <= '0;
						end
					end
					KIND_METHOD: begin
						params_left_q <= params_left_q - COUNT_W'(1);
						if (!same_mode_q) begin
							cur_method_q <= cur_method_q + METHOD_STEP;
						end
					end
					KIND_CALL: begin
						return_addr_q <= seq;
					end
					KIND_HEADER: begin
						params_left_q <= in_word[28:18];
						cur_subch_q   <= in_word[15:13];
						cur_method_q  <= {1'b0, in_word[12:2], 2'b00};
						same_mode_q   <= top == TOP_NONINC;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

### rtl/pcp_queue.sv
// ----------------------------------------------------------------------------
// pcp_queue
// Two-entry queue of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
module pcp_queue
	import pcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int unsigned DEPTH = 2;

	cmd_t                       mem_q [DEPTH];
	logic [$clog2(DEPTH)-1:0]   wr_ptr_q;
	logic [$clog2(DEPTH)-1:0]   rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign full       = count_q == ($clog2(DEPTH+1))'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/pcp_back.sv
// ----------------------------------------------------------------------------
// pcp_back
// Flags software methods and flips, and holds the result output register.
// ----------------------------------------------------------------------------
module pcp_back
	import pcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  cmd_t head_cmd,
	output logic pop,
	pcp_result_if.source result
);

	logic               valid_q;
	cmd_t               cmd_q;
	logic               sw_method_q;
	logic               flip_q;
	logic [FADDR_W-1:0] surf_q;

	logic               sw_method;
	logic               flip;
	logic [FADDR_W-1:0] surf;

	assign pop = head_valid && (!valid_q || result.ready);

	assign sw_method = head_cmd.kind == KIND_METHOD && head_cmd.subch == '0
		&& head_cmd.meth == SOFT_METHOD && head_cmd.value != '0;
	assign flip = sw_method && head_cmd.value[4:0] == FLIP_CODE;
	assign surf = flip ? FADDR_W'((head_cmd.value >> 5) & SURFACE_MASK) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q       <= head_cmd;
			sw_method_q <= sw_method;
			flip_q      <= flip;
			surf_q      <= surf;
		end
	end

	assign result.valid        = valid_q;
	assign result.kind         = cmd_q.kind;
	assign result.subchannel   = cmd_q.subch;
	assign result.method_addr  = cmd_q.meth;
	assign result.param_value  = cmd_q.value;
	assign result.next_fetch   = cmd_q.next_fetch;
	assign result.soft_method  = sw_method_q;
	assign result.flip_request = flip_q;
	assign result.flip_surface = surf_q;

endmodule
